>>> rtl/core/wbps_pkg.sv
package wbps_pkg;

    localparam int PATTERN_MAX_DEFAULT = 16;
    localparam int ADDR_W = 64;
    localparam int LEN_W = 5;
    localparam int MASK_W = 16;
    localparam int SIG_BYTES = 16;
    localparam int CFG_INDEX_W = 3;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t CFG_BASE_ADDRESS   = 3'd0;
    localparam cfg_index_t CFG_PATTERN_LOW    = 3'd1;
    localparam cfg_index_t CFG_PATTERN_HIGH   = 3'd2;
    localparam cfg_index_t CFG_WILDCARD_MASK  = 3'd3;
    localparam cfg_index_t CFG_PATTERN_LENGTH = 3'd4;
    localparam cfg_index_t CFG_RESULT_OFFSET  = 3'd5;

    typedef struct packed {
        logic [ADDR_W-1:0]      base_address;
        logic [8*SIG_BYTES-1:0] pattern;
        logic [MASK_W-1:0]      wildcard_mask;
        logic [LEN_W-1:0]       pattern_length;
        logic [ADDR_W-1:0]      result_offset;
    } wbps_cfg_t;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] start;
    } wbps_hit_t;

endpackage

>>> rtl/core/wbps_if.sv
interface wbps_scan_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbps_report_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [63:0] match_address;

    modport source (output valid, output found, output match_address, input ready);
    modport sink (input valid, input found, input match_address, output ready);
endinterface

>>> rtl/core/wbps_scan.sv
module wbps_scan
    import wbps_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  wbps_cfg_t    cfg,
    wbps_scan_if.sink    scan,
    output logic         hit_valid,
    input  logic         hit_ready,
    output wbps_hit_t    hit
);

    localparam int WIN_DEPTH = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
    localparam int FILL_W = $clog2(PATTERN_MAX + 1);

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_last_reg;
    logic [7:0]             window_reg [WIN_DEPTH];
    logic [ADDR_W-1:0]      count_reg;
    logic [FILL_W-1:0]      fill_reg;
    logic [FILL_W-1:0]      fill_next;
    logic                   seen_reg;
    logic [ADDR_W-1:0]      start_reg;
    logic                   advance;
    logic [7:0]             taps [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] len_hit;
    logic                   hit_sel;
    logic                   len_ok;
    logic                   fill_ok;
    logic                   hit_now;
    logic                   count_full;
    logic [LEN_W-1:0]       sub_amt;
    logic [ADDR_W-1:0]      start_new;

    assign advance    = in_valid_reg && (!in_last_reg || hit_ready);
    assign scan.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (scan.ready)
        begin
            in_valid_reg <= scan.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan.valid && scan.ready)
        begin
            in_byte_reg <= scan.data_byte;
            in_last_reg <= scan.last_byte;
        end
    end

    always_comb
    begin
        taps[0] = in_byte_reg;
        for (int d = 1; d < PATTERN_MAX; d++)
        begin
            taps[d] = window_reg[d-1];
        end
    end

    // one compare per candidate length
    always_comb
    begin
        logic ok;
        for (int l = 1; l <= PATTERN_MAX; l++)
        begin
            ok = 1'b1;
            for (int j = 0; j < l; j++)
            begin
                if (!cfg.wildcard_mask[j] && (taps[l-1-j] != cfg.pattern[8*j +: 8]))
                begin
                    ok = 1'b0;
                end
            end
            len_hit[l-1] = ok;
        end
    end

    always_comb
    begin
        hit_sel = 1'b0;
        for (int l = 1; l <= PATTERN_MAX; l++)
        begin
            if (cfg.pattern_length == LEN_W'(l))
            begin
                hit_sel = len_hit[l-1];
            end
        end
    end

    assign fill_next  = (fill_reg == FILL_W'(PATTERN_MAX)) ? fill_reg : fill_reg + 1'b1;
    assign len_ok     = (cfg.pattern_length != '0) &&
                        ({1'b0, cfg.pattern_length} <= (LEN_W+1)'(PATTERN_MAX));
    assign fill_ok    = (6'(fill_next) >= 6'(cfg.pattern_length));
    assign hit_now    = !seen_reg && len_ok && fill_ok && hit_sel;
    assign count_full = &count_reg;
    assign sub_amt    = count_full ? cfg.pattern_length : cfg.pattern_length - 1'b1;
    assign start_new  = count_reg - ADDR_W'(sub_amt);

    assign hit_valid = in_valid_reg && in_last_reg;
    assign hit.found = seen_reg || hit_now;
    assign hit.start = seen_reg ? start_reg : start_new;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            fill_reg  <= '0;
            seen_reg  <= 1'b0;
        end
        else if (advance)
        begin
            if (in_last_reg)
            begin
                count_reg <= '0;
                fill_reg  <= '0;
                seen_reg  <= 1'b0;
            end
            else
            begin
                count_reg <= count_full ? count_reg : count_reg + 1'b1;
                fill_reg  <= fill_next;
                if (hit_now)
                begin
                    seen_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && hit_now)
        begin
            start_reg <= start_new;
        end
    end

    // shift newest byte in
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            window_reg[0] <= in_byte_reg;
            for (int d = 1; d < WIN_DEPTH; d++)
            begin
                window_reg[d] <= window_reg[d-1];
            end
        end
    end

endmodule

>>> rtl/core/wbps_addr.sv
module wbps_addr
    import wbps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [ADDR_W-1:0]  base_address,
    input  logic [ADDR_W-1:0]  result_offset,
    input  logic               hit_valid,
    output logic               hit_ready,
    input  wbps_hit_t          hit,
    wbps_report_if.source      report
);

    logic              a_valid_reg;
    logic              a_found_reg;
    logic [ADDR_W-1:0] a_start_reg;
    logic              b_valid_reg;
    logic              b_found_reg;
    logic [ADDR_W-1:0] b_sum_reg;
    logic              o_valid_reg;
    logic              o_found_reg;
    logic [ADDR_W-1:0] o_addr_reg;
    logic              o_load;
    logic              b_adv;
    logic              b_load;
    logic              a_adv;
    logic              a_load;

    assign o_load    = !o_valid_reg || report.ready;
    assign b_adv     = b_valid_reg && o_load;
    assign b_load    = !b_valid_reg || b_adv;
    assign a_adv     = a_valid_reg && b_load;
    assign a_load    = !a_valid_reg || a_adv;
    assign hit_ready = a_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_load)
            begin
                a_valid_reg <= hit_valid;
            end
            if (b_load)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (o_load)
            begin
                o_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load && hit_valid)
        begin
            a_found_reg <= hit.found;
            a_start_reg <= hit.start;
        end
        if (a_adv)
        begin
            b_found_reg <= a_found_reg && (base_address != '0);
            b_sum_reg   <= a_start_reg + base_address;
        end
        if (b_adv)
        begin
            o_found_reg <= b_found_reg;
            o_addr_reg  <= b_found_reg ? b_sum_reg + result_offset : '0;
        end
    end

    assign report.valid         = o_valid_reg;
    assign report.found         = o_found_reg;
    assign report.match_address = o_addr_reg;

endmodule

>>> rtl/core/wildcard_byte_pattern_scanner.sv
// Results: a request marked last_byte shows its result on report after passing the input
//   register and the a, b and o address stages; other requests give no result. Throughput:
//   one byte per cycle, set by the input register and the window compare, while no last_byte
//   request waits on full address stages. Reset: rst_n (asynchronous, active low) zeroes the
//   configuration, the scan state and all stage valid flags; requests are accepted after it.
module wildcard_byte_pattern_scanner
    import wbps_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  cfg_index_t        cfg_index,
    input  logic [ADDR_W-1:0] cfg_data,
    wbps_scan_if.sink         scan,
    wbps_report_if.source     report
);

    wbps_cfg_t cfg_reg;
    wbps_hit_t hit;
    logic      hit_valid;
    logic      hit_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_BASE_ADDRESS:   cfg_reg.base_address     <= cfg_data;
                CFG_PATTERN_LOW:    cfg_reg.pattern[63:0]    <= cfg_data;
                CFG_PATTERN_HIGH:   cfg_reg.pattern[127:64]  <= cfg_data;
                CFG_WILDCARD_MASK:  cfg_reg.wildcard_mask    <= cfg_data[MASK_W-1:0];
                CFG_PATTERN_LENGTH: cfg_reg.pattern_length   <= cfg_data[LEN_W-1:0];
                CFG_RESULT_OFFSET:  cfg_reg.result_offset    <= cfg_data;
                default:            cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    wbps_scan #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .scan      (scan),
        .hit_valid (hit_valid),
        .hit_ready (hit_ready),
        .hit       (hit)
    );

    wbps_addr u_addr (
        .clk           (clk),
        .rst_n         (rst_n),
        .base_address  (cfg_reg.base_address),
        .result_offset (cfg_reg.result_offset),
        .hit_valid     (hit_valid),
        .hit_ready     (hit_ready),
        .hit           (hit),
        .report        (report)
    );

endmodule

>>> rtl/core/wbps_checker.sv
module wbps_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        scan_valid,
    input logic        scan_ready,
    input logic        scan_last,
    input logic        report_valid,
    input logic        report_ready,
    input logic        report_found,
    input logic [63:0] report_address
);

    logic [2:0] pending_reg;
    logic [2:0] pending_next;
    logic       last_in;
    logic       result_out;

    assign last_in    = scan_valid && scan_ready && scan_last;
    assign result_out = report_valid && report_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (last_in && !result_out)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (!last_in && result_out)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_report_hold: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && !report_ready |=> report_valid && $stable(report_address))
        else $error("report request dropped or changed while stalled");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && !report_found |-> report_address == 64'd0)
        else $error("not-found result carries a nonzero address");

    a_result_has_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_out |-> pending_reg != 3'd0)
        else $error("result delivered without an accepted last byte");

    a_in_flight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        last_in |=> pending_reg <= 3'd4)
        else $error("more regions in flight than pipeline stages");

endmodule

bind wildcard_byte_pattern_scanner wbps_checker u_wbps_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .scan_valid     (scan.valid),
    .scan_ready     (scan.ready),
    .scan_last      (scan.last_byte),
    .report_valid   (report.valid),
    .report_ready   (report.ready),
    .report_found   (report.found),
    .report_address (report.match_address)
);

>>> bench/wildcard_byte_pattern_scanner_checker.sv
`timescale 1ns / 100ps

module wildcard_byte_pattern_scanner_checker
    import wbps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  cfg_index_t        cfg_index,
    input  logic [ADDR_W-1:0] cfg_data,
    wbps_scan_if              scan,
    wbps_report_if            report,
    output int                failures,
    output int                outstanding
);

    localparam int LEN_LIMIT = PATTERN_MAX_DEFAULT;
    localparam int HISTORY_DEPTH = PATTERN_MAX_DEFAULT - 1;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] match_address;
    } scan_report_t;

    logic [ADDR_W-1:0]      base_q;
    logic [8*SIG_BYTES-1:0] sig_q;
    logic [MASK_W-1:0]      mask_q;
    logic [LEN_W-1:0]       len_q;
    logic [ADDR_W-1:0]      offset_q;

    logic [7:0]        history [HISTORY_DEPTH];
    logic [ADDR_W-1:0] seen_bytes;
    logic              hit_latched;
    logic [ADDR_W-1:0] hit_start;

    scan_report_t pending_reports [$];
    scan_report_t oldest;

    task automatic clear_region();
        foreach (history[i])
            history[i] = 8'h00;
        seen_bytes = '0;
        hit_latched = 1'b0;
        hit_start = '0;
    endtask

    task automatic take_byte(input logic [7:0] value, input logic closes);
        logic         hit;
        logic [7:0]   probe;
        int           depth_back;
        scan_report_t outcome;

        if (seen_bytes != '1)
            seen_bytes = seen_bytes + 1'b1;

        if (!hit_latched && len_q >= 1 && len_q <= LEN_LIMIT && seen_bytes >= len_q)
        begin
            hit = 1'b1;
            for (int j = 0; j < len_q; j++)
            begin
                depth_back = len_q - 1 - j;
                probe = (depth_back == 0) ? value : history[depth_back-1];
                if (!mask_q[j] && probe != sig_q[8*j +: 8])
                    hit = 1'b0;
            end
            if (hit)
            begin
                hit_latched = 1'b1;
                hit_start = seen_bytes - len_q;
            end
        end

        for (int i = HISTORY_DEPTH - 1; i > 0; i--)
            history[i] = history[i-1];
        history[0] = value;

        if (closes)
        begin
            outcome.found = hit_latched && (base_q != '0);
            outcome.match_address = outcome.found ? base_q + hit_start + offset_q : '0;
            pending_reports.insert(pending_reports.size(), outcome);
            clear_region();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_q = '0;
            sig_q = '0;
            mask_q = '0;
            len_q = '0;
            offset_q = '0;
            clear_region();
            pending_reports.delete();
            failures = 0;
            outstanding = 0;
        end
        else
        begin
            if (report.valid && report.ready)
            begin
                if (pending_reports.size() == 0)
                begin
                    failures++;
                    $display("%0t: report with none pending: expected none, actual found=%0b address=%h",
                             $time, report.found, report.match_address);
                end
                else
                begin
                    oldest = pending_reports.pop_front();
                    if (report.found !== oldest.found)
                    begin
                        failures++;
                        $display("%0t: found mismatch: expected %0b, actual %0b",
                                 $time, oldest.found, report.found);
                    end
                    if (report.match_address !== oldest.match_address)
                    begin
                        failures++;
                        $display("%0t: match_address mismatch: expected %h, actual %h",
                                 $time, oldest.match_address, report.match_address);
                    end
                end
            end

            if (scan.valid && scan.ready)
                take_byte(scan.data_byte, scan.last_byte);

            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_BASE_ADDRESS:   base_q = cfg_data;
                    CFG_PATTERN_LOW:    sig_q[63:0] = cfg_data;
                    CFG_PATTERN_HIGH:   sig_q[127:64] = cfg_data;
                    CFG_WILDCARD_MASK:  mask_q = cfg_data[MASK_W-1:0];
                    CFG_PATTERN_LENGTH: len_q = cfg_data[LEN_W-1:0];
                    CFG_RESULT_OFFSET:  offset_q = cfg_data;
                    default:            ;
                endcase
            end

            outstanding = pending_reports.size();
        end
    end

endmodule

>>> bench/wildcard_byte_pattern_scanner_tb.sv
`timescale 1ns / 100ps

module wildcard_byte_pattern_scanner_tb;
    import wbps_pkg::*;

    localparam int REGION_MAX = 48;
    localparam cfg_index_t CFG_SPARE_A = 3'd6;
    localparam cfg_index_t CFG_SPARE_B = 3'd7;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_write;
    cfg_index_t        cfg_index;
    logic [ADDR_W-1:0] cfg_data;

    int failures;
    int outstanding;
    bit pacing = 1'b0;
    bit hold_report = 1'b0;
    int sent_bytes = 0;
    int phase;

    logic [8*SIG_BYTES-1:0] sig;
    logic [MASK_W-1:0]      wild;
    logic [LEN_W-1:0]       sig_len;
    logic [7:0]             region [REGION_MAX];
    int                     region_len;

    wbps_scan_if   scan_ch();
    wbps_report_if report_ch();

    wildcard_byte_pattern_scanner u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .scan      (scan_ch),
        .report    (report_ch)
    );

    wildcard_byte_pattern_scanner_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .scan        (scan_ch),
        .report      (report_ch),
        .failures    (failures),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic write_reg(input cfg_index_t idx, input logic [ADDR_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
    endtask

    task automatic load_signature(input logic [ADDR_W-1:0] base, input logic [63:0] lo,
                                  input logic [63:0] hi, input logic [MASK_W-1:0] mask,
                                  input logic [LEN_W-1:0] len,
                                  input logic [ADDR_W-1:0] offset);
        write_reg(CFG_BASE_ADDRESS, base);
        write_reg(CFG_PATTERN_LOW, lo);
        write_reg(CFG_PATTERN_HIGH, hi);
        write_reg(CFG_WILDCARD_MASK, ADDR_W'(mask));
        write_reg(CFG_PATTERN_LENGTH, ADDR_W'(len));
        write_reg(CFG_RESULT_OFFSET, offset);
        cfg_write <= 1'b0;
        sig = {hi, lo};
        wild = mask;
        sig_len = len;
    endtask

    task automatic send_byte(input logic [7:0] value, input logic closes);
        if (pacing && $urandom_range(0, 4) == 0)
        begin
            scan_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        scan_ch.valid <= 1'b1;
        scan_ch.data_byte <= value;
        scan_ch.last_byte <= closes;
        do
            @(posedge clk);
        while (!scan_ch.ready);
        @(negedge clk);
        sent_bytes++;
    endtask

    // drop valid, wait out every pending report, then let the pipeline drain
    task automatic settle();
        scan_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic random_signature();
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] offset;
        logic [63:0]       lo;
        logic [63:0]       hi;
        logic [MASK_W-1:0] mask;
        logic [LEN_W-1:0]  len;
        int                pick;

        pick = $urandom_range(0, 9);
        base = (pick == 0) ? '0 : (pick == 1) ? '1 : {$urandom, $urandom};
        pick = $urandom_range(0, 9);
        offset = (pick == 0) ? '0 : (pick == 1) ? '1 : {$urandom, $urandom};
        pick = $urandom_range(0, 9);
        lo = (pick == 0) ? '1 : (pick == 1) ? '0 : {$urandom, $urandom};
        hi = (pick == 0) ? '1 : (pick == 1) ? '0 : {$urandom, $urandom};
        pick = $urandom_range(0, 9);
        mask = (pick == 0) ? '1 : (pick < 4) ? '0 : MASK_W'($urandom & $urandom);
        pick = $urandom_range(0, 19);
        case (pick)
            0:       len = '0;
            1:       len = LEN_W'($urandom_range(17, 31));
            2:       len = LEN_W'(16);
            3:       len = LEN_W'(1);
            default: len = LEN_W'($urandom_range(1, 16));
        endcase
        load_signature(base, lo, hi, mask, len, offset);
        if ($urandom_range(0, 5) == 0)
        begin
            write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, {$urandom, $urandom});
            cfg_write <= 1'b0;
        end
    endtask

    task automatic build_region(input int count);
        int mode;
        int at;
        int k;

        region_len = count;
        mode = $urandom_range(0, 2);
        for (int i = 0; i < count; i++)
        begin
            case (mode)
                0:       region[i] = 8'($urandom);
                1:       region[i] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                default: region[i] = sig[8*$urandom_range(0, SIG_BYTES-1) +: 8];
            endcase
        end
        if (sig_len >= 1 && sig_len <= SIG_BYTES && count >= sig_len &&
            $urandom_range(0, 9) < 7)
        begin
            at = $urandom_range(0, count - sig_len);
            for (int j = 0; j < sig_len; j++)
                if (!wild[j])
                    region[at+j] = sig[8*j +: 8];
            // break the signature now and then
            if ($urandom_range(0, 4) == 0)
            begin
                k = $urandom_range(0, sig_len - 1);
                region[at+k] = region[at+k] ^ (8'h01 << $urandom_range(0, 7));
            end
        end
    endtask

    task automatic send_region();
        for (int i = 0; i < region_len; i++)
            send_byte(region[i], i == region_len - 1);
    endtask

    initial
    begin
        report_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_report)
            begin
                report_ch.ready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_report = 1'b0;
            end
            else if (pacing && $urandom_range(0, 5) == 0)
            begin
                report_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 4) - 1) @(negedge clk);
            end
            else
                report_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        #2_000_000;
        $display("wildcard_byte_pattern_scanner regression: fail");
        $finish;
    end

    initial
    begin
        logic [7:0] value;

        scan_ch.valid = 1'b0;
        scan_ch.data_byte = 8'h00;
        scan_ch.last_byte = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_BASE_ADDRESS;
        cfg_data = '0;
        sig = '0;
        wild = '0;
        sig_len = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset registers: zero length never matches
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        settle();

        // address wraps past the top
        load_signature('1, 64'h0000_0000_0000_00FF, '0, '0, 5'd2, '1);
        send_byte(8'h12, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        settle();

        write_reg(CFG_BASE_ADDRESS, '0);
        cfg_write <= 1'b0;
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        settle();

        // full-length signature, base moved while the region is open
        load_signature(64'h1000, 64'h8877_6655_4433_2211, 64'h00FF_EEDD_CCBB_AA99,
                       16'hA5A5, 5'd16, 64'h10);
        write_reg(CFG_SPARE_A, '1);
        write_reg(CFG_SPARE_B, '1);
        cfg_write <= 1'b0;
        for (int k = 0; k < SIG_BYTES - 1; k++)
        begin
            value = wild[k] ? 8'($urandom) : sig[8*k +: 8];
            send_byte(value, 1'b0);
        end
        settle();
        write_reg(CFG_BASE_ADDRESS, 64'h2000);
        cfg_write <= 1'b0;
        value = wild[SIG_BYTES-1] ? 8'($urandom) : sig[8*(SIG_BYTES-1) +: 8];
        send_byte(value, 1'b1);
        settle();

        // length above the maximum matches nothing, even all wildcards
        load_signature(64'h1, '0, '0, '1, 5'd17, '0);
        send_byte(8'hA5, 1'b1);
        settle();

        pacing = 1'b1;
        phase = 0;
        while (sent_bytes < 700)
        begin
            random_signature();
            if (phase == 1)
            begin
                // hold off reports while one-byte regions keep coming
                hold_report = 1'b1;
                repeat (40) send_byte(8'($urandom), 1'b1);
            end
            repeat ($urandom_range(3, 8))
            begin
                build_region($urandom_range(0, 7) == 0 ? 1 : $urandom_range(1, REGION_MAX));
                send_region();
            end
            settle();
            phase++;
        end

        pacing = 1'b0;
        random_signature();
        while (sent_bytes < 800)
        begin
            build_region($urandom_range(1, 32));
            send_region();
        end
        settle();

        if (failures == 0)
            $display("wildcard_byte_pattern_scanner regression: pass");
        else
            $display("wildcard_byte_pattern_scanner regression: fail");
        $finish;
    end

endmodule

>>> files.f
rtl/core/wbps_pkg.sv
rtl/core/wbps_if.sv
rtl/core/wbps_scan.sv
rtl/core/wbps_addr.sv
rtl/core/wildcard_byte_pattern_scanner.sv
rtl/core/wbps_checker.sv
bench/wildcard_byte_pattern_scanner_checker.sv
bench/wildcard_byte_pattern_scanner_tb.sv
